>>> sv/sanp_pkg.sv
package sanp_pkg;

  // parse phases of one message
  typedef enum logic [3:0] {
    PH_DIGEST,
    PH_HEADER,
    PH_IDENT,
    PH_BODY,
    PH_STYPE,
    PH_CTYPE,
    PH_ULEN,
    PH_URI,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DIGEST,
    KIND_HEADER_DONE,
    KIND_IDENT,
    KIND_SYNC_TYPE,
    KIND_CONTENT_TYPE,
    KIND_URI,
    KIND_IGNORED
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_SHORT_DIGEST,
    ST_SHORT_HEADER,
    ST_BAD_VERSION,
    ST_SHORT_ID,
    ST_BODY,
    ST_ZERO_SYNCS,
    ST_SHORT_INFO,
    ST_SHORT_URI
  } status_t;

  typedef enum logic [2:0] {
    CC_NONE,
    CC_CONTACTS,
    CC_CALENDAR,
    CC_NOTES,
    CC_UNSUPPORTED
  } content_code_t;

  localparam logic [3:0] DIGEST_LAST    = 4'd15;
  localparam logic [3:0] HDR_BYTE_HI    = 4'd0;
  localparam logic [3:0] HDR_BYTE_LO    = 4'd1;
  localparam logic [3:0] HDR_SESSION_HI = 4'd5;
  localparam logic [3:0] HDR_SESSION_LO = 4'd6;
  localparam logic [3:0] HDR_LAST       = 4'd7;
  localparam logic [3:0] CT_FIRST       = 4'd0;
  localparam logic [3:0] CT_SECOND      = 4'd1;

  localparam logic [9:0] VER_1_1 = 10'h00B;
  localparam logic [9:0] VER_1_2 = 10'h00C;

  localparam logic [7:0] ALERT_BASE  = 8'd200;
  localparam logic [7:0] CT_CONTACTS = 8'h07;
  localparam logic [7:0] CT_CALENDAR = 8'h06;
  localparam logic [7:0] CT_NOTES    = 8'h03;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] byte_count;
    logic [7:0] hdr_hi;
    logic [7:0] hdr_lo;
    logic [7:0] session_high;
    logic [7:0] field_remaining;
    logic [3:0] syncs_remaining;
    logic [3:0] current_sync;
    logic       content_nz;
    status_t    error_code;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_DIGEST,
    byte_count:      4'd0,
    hdr_hi:          8'd0,
    hdr_lo:          8'd0,
    session_high:    8'd0,
    field_remaining: 8'd0,
    syncs_remaining: 4'd0,
    current_sync:    4'd0,
    content_nz:      1'b0,
    error_code:      ST_OK
  };

  typedef struct packed {
    kind_t         item_kind;
    logic [7:0]    data_byte;
    logic          version_code;
    logic [1:0]    ui_mode;
    logic          server_init;
    logic [15:0]   session_id;
    logic [7:0]    sync_type;
    content_code_t content_code;
    logic [3:0]    sync_index;
    logic          message_done;
    status_t       status;
  } result_t;

endpackage

>>> sv/san_notification_parser.sv
// Streaming parser for a server-alerted notification message, one byte per
// transaction. Every input byte yields exactly one result transaction, offered
// from the result register in the cycle after the byte is taken. A byte is taken
// in every cycle while that register is empty or drained, so throughput is one
// byte per cycle unless out_ready holds it back. The message is a 16-byte
// digest, an 8-byte header (version, ui mode, initiator, session id, identifier
// length), the server identifier and, in data-sync mode, a sync list. Header
// fields come out together on the header-done item. Errors are latched and the
// final status is given with message_done on the byte flagged end_of_message,
// after which the parser is back at its start state. The user writes
// expect_empty_body (1 for device management) through the cfg channel between
// messages, which the block does not enforce; it holds over message boundaries.
module san_notification_parser (
  input  logic        clk,
  input  logic        rst,

  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,

  // message byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        end_of_message,

  // parsed item stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  item_kind,
  output logic [7:0]  data_byte,
  output logic        version_code,
  output logic [1:0]  ui_mode,
  output logic        server_init,
  output logic [15:0] session_id,
  output logic [7:0]  sync_type,
  output logic [2:0]  content_code,
  output logic [3:0]  sync_index,
  output logic        message_done,
  output logic [3:0]  status
);

  logic                   expect_empty_body;
  sanp_pkg::parse_state_t state;
  sanp_pkg::parse_state_t state_next;
  sanp_pkg::result_t      result;
  sanp_pkg::result_t      result_next;
  logic                   in_take;

  // config register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_empty_body <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      expect_empty_body <= cfg_data;
    end
  end

  // result register frees up in the same cycle it is drained
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  sanp_step u_step (
    .cur               (state),
    .msg_byte          (msg_byte),
    .end_of_message    (end_of_message),
    .expect_empty_body (expect_empty_body),
    .nxt               (state_next),
    .res               (result_next)
  );

  // parse state only moves on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sanp_pkg::STATE_RESET;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      result <= result_next;
    end
  end

  assign item_kind    = result.item_kind;
  assign data_byte    = result.data_byte;
  assign version_code = result.version_code;
  assign ui_mode      = result.ui_mode;
  assign server_init  = result.server_init;
  assign session_id   = result.session_id;
  assign sync_type    = result.sync_type;
  assign content_code = result.content_code;
  assign sync_index   = result.sync_index;
  assign message_done = result.message_done;
  assign status       = result.status;

endmodule

>>> sv/sanp_step.sv
module sanp_step (
  input  sanp_pkg::parse_state_t cur,
  input  logic [7:0]             msg_byte,
  input  logic                   end_of_message,
  input  logic                   expect_empty_body,
  output sanp_pkg::parse_state_t nxt,
  output sanp_pkg::result_t      res
);

  logic [9:0] ver;
  logic [3:0] syncs_dec;
  logic [7:0] field_dec;
  sanp_pkg::parse_state_t upd;
  sanp_pkg::status_t      end_st;
  sanp_pkg::result_t      item;

  assign ver       = {cur.hdr_hi, cur.hdr_lo[7:6]};
  assign syncs_dec = cur.syncs_remaining - 4'd1;
  assign field_dec = cur.field_remaining - 8'd1;

  always_comb begin
    upd = cur;
    item = '0;
    item.item_kind = sanp_pkg::KIND_IGNORED;

    unique case (cur.phase)
      sanp_pkg::PH_DIGEST: begin
        item.item_kind = sanp_pkg::KIND_DIGEST;
        item.data_byte = msg_byte;
        if (cur.byte_count == sanp_pkg::DIGEST_LAST) begin
          upd.phase      = sanp_pkg::PH_HEADER;
          upd.byte_count = 4'd0;
        end else begin
          upd.byte_count = cur.byte_count + 4'd1;
        end
      end
      sanp_pkg::PH_HEADER: begin
        case (cur.byte_count)
          sanp_pkg::HDR_BYTE_HI:    upd.hdr_hi          = msg_byte;
          sanp_pkg::HDR_BYTE_LO:    upd.hdr_lo          = msg_byte;
          sanp_pkg::HDR_SESSION_HI: upd.session_high    = msg_byte;
          sanp_pkg::HDR_SESSION_LO: upd.field_remaining = msg_byte;
          default: ;
        endcase
        if (cur.byte_count == sanp_pkg::HDR_LAST) begin
          if (ver == sanp_pkg::VER_1_1 || ver == sanp_pkg::VER_1_2) begin
            item.item_kind      = sanp_pkg::KIND_HEADER_DONE;
            item.version_code   = (ver == sanp_pkg::VER_1_2);
            item.ui_mode        = cur.hdr_lo[5:4];
            item.server_init    = cur.hdr_lo[3];
            item.session_id     = {cur.session_high, cur.field_remaining};
            upd.field_remaining = msg_byte;
            upd.phase           = (msg_byte != 8'd0) ? sanp_pkg::PH_IDENT
                                                     : sanp_pkg::PH_BODY;
            upd.byte_count      = 4'd0;
          end else begin
            upd.error_code = sanp_pkg::ST_BAD_VERSION;
            upd.phase      = sanp_pkg::PH_ERROR;
          end
        end else begin
          upd.byte_count = cur.byte_count + 4'd1;
        end
      end
      sanp_pkg::PH_IDENT: begin
        item.item_kind      = sanp_pkg::KIND_IDENT;
        item.data_byte      = msg_byte;
        upd.field_remaining = field_dec;
        if (field_dec == 8'd0) begin
          upd.phase = sanp_pkg::PH_BODY;
        end
      end
      sanp_pkg::PH_BODY: begin
        if (expect_empty_body) begin
          upd.error_code = sanp_pkg::ST_BODY;
          upd.phase      = sanp_pkg::PH_ERROR;
        end else if (msg_byte[7:4] == 4'd0) begin
          upd.error_code = sanp_pkg::ST_ZERO_SYNCS;
          upd.phase      = sanp_pkg::PH_ERROR;
        end else begin
          upd.syncs_remaining = msg_byte[7:4];
          upd.current_sync    = 4'd0;
          upd.phase           = sanp_pkg::PH_STYPE;
        end
      end
      sanp_pkg::PH_STYPE: begin
        item.item_kind  = sanp_pkg::KIND_SYNC_TYPE;
        item.sync_type  = sanp_pkg::ALERT_BASE + {4'd0, msg_byte[7:4]};
        item.sync_index = cur.current_sync;
        upd.phase       = sanp_pkg::PH_CTYPE;
        upd.byte_count  = 4'd0;
      end
      sanp_pkg::PH_CTYPE: begin
        if (cur.byte_count == sanp_pkg::CT_FIRST) begin
          upd.content_nz = (msg_byte != 8'd0);
          upd.byte_count = 4'd1;
        end else if (cur.byte_count == sanp_pkg::CT_SECOND) begin
          upd.content_nz = cur.content_nz | (msg_byte != 8'd0);
          upd.byte_count = 4'd2;
        end else begin
          item.item_kind  = sanp_pkg::KIND_CONTENT_TYPE;
          item.sync_index = cur.current_sync;
          if (cur.content_nz) begin
            item.content_code = sanp_pkg::CC_UNSUPPORTED;
          end else if (msg_byte == 8'd0) begin
            item.content_code = sanp_pkg::CC_NONE;
          end else if (msg_byte == sanp_pkg::CT_CONTACTS) begin
            item.content_code = sanp_pkg::CC_CONTACTS;
          end else if (msg_byte == sanp_pkg::CT_CALENDAR) begin
            item.content_code = sanp_pkg::CC_CALENDAR;
          end else if (msg_byte == sanp_pkg::CT_NOTES) begin
            item.content_code = sanp_pkg::CC_NOTES;
          end else begin
            item.content_code = sanp_pkg::CC_UNSUPPORTED;
          end
          upd.phase      = sanp_pkg::PH_ULEN;
          upd.byte_count = 4'd0;
        end
      end
      sanp_pkg::PH_ULEN: begin
        upd.field_remaining = msg_byte;
        if (msg_byte == 8'd0) begin
          upd.current_sync    = cur.current_sync + 4'd1;
          upd.syncs_remaining = syncs_dec;
          upd.phase = (syncs_dec != 4'd0) ? sanp_pkg::PH_STYPE : sanp_pkg::PH_TRAIL;
        end else begin
          upd.phase = sanp_pkg::PH_URI;
        end
      end
      sanp_pkg::PH_URI: begin
        item.item_kind      = sanp_pkg::KIND_URI;
        item.data_byte      = msg_byte;
        item.sync_index     = cur.current_sync;
        upd.field_remaining = field_dec;
        if (field_dec == 8'd0) begin
          upd.current_sync    = cur.current_sync + 4'd1;
          upd.syncs_remaining = syncs_dec;
          upd.phase = (syncs_dec != 4'd0) ? sanp_pkg::PH_STYPE : sanp_pkg::PH_TRAIL;
        end
      end
      sanp_pkg::PH_TRAIL, sanp_pkg::PH_ERROR: ;
      default: upd.phase = sanp_pkg::PH_ERROR;
    endcase
  end

  // final status is judged on the phase reached after this byte
  always_comb begin
    if (upd.error_code != sanp_pkg::ST_OK) begin
      end_st = upd.error_code;
    end else begin
      unique case (upd.phase)
        sanp_pkg::PH_DIGEST: end_st = sanp_pkg::ST_SHORT_DIGEST;
        sanp_pkg::PH_HEADER: end_st = sanp_pkg::ST_SHORT_HEADER;
        sanp_pkg::PH_IDENT:  end_st = sanp_pkg::ST_SHORT_ID;
        sanp_pkg::PH_BODY:   end_st = expect_empty_body ? sanp_pkg::ST_OK
                                                        : sanp_pkg::ST_BODY;
        sanp_pkg::PH_STYPE,
        sanp_pkg::PH_CTYPE,
        sanp_pkg::PH_ULEN:   end_st = sanp_pkg::ST_SHORT_INFO;
        sanp_pkg::PH_URI:    end_st = sanp_pkg::ST_SHORT_URI;
        sanp_pkg::PH_TRAIL:  end_st = sanp_pkg::ST_OK;
        default:             end_st = sanp_pkg::ST_BODY;
      endcase
    end
  end

  // last byte carries the status and sends the parser back to its start
  always_comb begin
    nxt = upd;
    res = item;
    if (end_of_message) begin
      nxt              = sanp_pkg::STATE_RESET;
      res.message_done = 1'b1;
      res.status       = end_st;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // shape given to one random message before it is sent
  typedef enum int {
    FL_CLEAN,
    FL_TRAILING,
    FL_CUT,
    FL_BAD_VERSION,
    FL_ZERO_COUNT,
    FL_OTHER_MODE
  } flavour_t;

  localparam int NUM_FLAVOURS = 6;

  // how the result side takes transactions for a while
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_style_t;

  localparam int ITEM_TARGET = 1650;

  // one row of the directed table: byte, end flag and, where typed in, the result
  typedef struct {
    logic [7:0]        msg_byte;
    logic              eom;
    bit                typed;
    sanp_pkg::result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  item_kind;
  logic [7:0]  data_byte;
  logic        version_code;
  logic [1:0]  ui_mode;
  logic        server_init;
  logic [15:0] session_id;
  logic [7:0]  sync_type;
  logic [2:0]  content_code;
  logic [3:0]  sync_index;
  logic        message_done;
  logic [3:0]  status;

  // parser state as the testbench sees it
  sanp_pkg::phase_t  prs_phase;
  logic [7:0]        prs_count;
  logic [15:0]       prs_header;
  logic [7:0]        prs_session_hi;
  logic [7:0]        prs_remaining;
  logic [3:0]        prs_syncs_left;
  logic [3:0]        prs_sync_no;
  logic [15:0]       prs_content;
  sanp_pkg::status_t prs_error;
  logic              empty_body_mode = 1'b0;

  sanp_pkg::result_t items_due[$];
  sanp_pkg::result_t item_want;
  logic [7:0]        msg_bytes[$];
  dir_row_t          directed_rows[26];
  int                mismatch_count = 0;
  int                bytes_counted = 0;
  int                burst_left = 0;
  rx_style_t         rx_style = RX_OPEN;
  int                rx_style_left = 0;
  int unsigned       rx_tick = 0;

  san_notification_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .msg_byte       (msg_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .data_byte      (data_byte),
    .version_code   (version_code),
    .ui_mode        (ui_mode),
    .server_init    (server_init),
    .session_id     (session_id),
    .sync_type      (sync_type),
    .content_code   (content_code),
    .sync_index     (sync_index),
    .message_done   (message_done),
    .status         (status)
  );

  always #4 clk = ~clk;

  // back to the start of a message; the mode bit is kept
  function automatic void clear_parse_state();
    prs_phase      = sanp_pkg::PH_DIGEST;
    prs_count      = '0;
    prs_header     = '0;
    prs_session_hi = '0;
    prs_remaining  = '0;
    prs_syncs_left = '0;
    prs_sync_no    = '0;
    prs_content    = '0;
    prs_error      = sanp_pkg::ST_OK;
  endfunction

  // one sync entry is complete, move to the next or to the trailing bytes
  function automatic void close_sync();
    prs_sync_no    = prs_sync_no + 4'd1;
    prs_syncs_left = prs_syncs_left - 4'd1;
    prs_phase      = (prs_syncs_left != 0) ? sanp_pkg::PH_STYPE : sanp_pkg::PH_TRAIL;
  endfunction

  // the parsed item that one message byte yields, advancing the parser state
  function automatic sanp_pkg::result_t parse_next_byte(input logic [7:0] b,
                                                        input logic last);
    sanp_pkg::result_t       r;
    logic [9:0]              ver;
    sanp_pkg::content_code_t cc;
    r = '0;
    r.item_kind = sanp_pkg::KIND_IGNORED;
    case (prs_phase)
      sanp_pkg::PH_DIGEST: begin
        r.item_kind = sanp_pkg::KIND_DIGEST;
        r.data_byte = b;
        prs_count++;
        if (prs_count > sanp_pkg::DIGEST_LAST) begin
          prs_phase = sanp_pkg::PH_HEADER;
          prs_count = '0;
        end
      end
      sanp_pkg::PH_HEADER: begin
        case (prs_count)
          sanp_pkg::HDR_BYTE_HI:    prs_header = {b, 8'h00};
          sanp_pkg::HDR_BYTE_LO:    prs_header = prs_header | {8'h00, b};
          sanp_pkg::HDR_SESSION_HI: prs_session_hi = b;
          sanp_pkg::HDR_SESSION_LO: prs_remaining = b;
          default: ;
        endcase
        if (prs_count >= sanp_pkg::HDR_LAST) begin
          // version is the high byte followed by the top two bits of the low byte
          ver = {prs_header[15:8], prs_header[7:6]};
          if (ver == sanp_pkg::VER_1_1 || ver == sanp_pkg::VER_1_2) begin
            r.item_kind    = sanp_pkg::KIND_HEADER_DONE;
            r.version_code = (ver == sanp_pkg::VER_1_2);
            r.ui_mode      = prs_header[5:4];
            r.server_init  = prs_header[3];
            r.session_id   = {prs_session_hi, prs_remaining};
            prs_remaining  = b;
            prs_phase      = (b != 0) ? sanp_pkg::PH_IDENT : sanp_pkg::PH_BODY;
            prs_count      = '0;
          end else begin
            prs_error = sanp_pkg::ST_BAD_VERSION;
            prs_phase = sanp_pkg::PH_ERROR;
          end
        end else begin
          prs_count++;
        end
      end
      sanp_pkg::PH_IDENT: begin
        r.item_kind = sanp_pkg::KIND_IDENT;
        r.data_byte = b;
        prs_remaining--;
        if (prs_remaining == 0) prs_phase = sanp_pkg::PH_BODY;
      end
      sanp_pkg::PH_BODY: begin
        if (empty_body_mode) begin
          prs_error = sanp_pkg::ST_BODY;
          prs_phase = sanp_pkg::PH_ERROR;
        end else if (b[7:4] == 4'h0) begin
          prs_error = sanp_pkg::ST_ZERO_SYNCS;
          prs_phase = sanp_pkg::PH_ERROR;
        end else begin
          prs_syncs_left = b[7:4];
          prs_sync_no    = '0;
          prs_phase      = sanp_pkg::PH_STYPE;
        end
      end
      sanp_pkg::PH_STYPE: begin
        r.item_kind  = sanp_pkg::KIND_SYNC_TYPE;
        r.sync_type  = sanp_pkg::ALERT_BASE + {4'h0, b[7:4]};
        r.sync_index = prs_sync_no;
        prs_phase    = sanp_pkg::PH_CTYPE;
        prs_count    = '0;
      end
      sanp_pkg::PH_CTYPE: begin
        if (prs_count == sanp_pkg::CT_FIRST) begin
          prs_content = {8'h00, b};
          prs_count   = 8'd1;
        end else if (prs_count == sanp_pkg::CT_SECOND) begin
          // anything non-zero in the upper bytes makes the value wide
          prs_content = ((prs_content != 0) ? 16'h0100 : 16'h0000) | {8'h00, b};
          prs_count   = 8'd2;
        end else begin
          if (prs_content != 0) cc = sanp_pkg::CC_UNSUPPORTED;
          else begin
            case (b)
              8'h00:                 cc = sanp_pkg::CC_NONE;
              sanp_pkg::CT_CONTACTS: cc = sanp_pkg::CC_CONTACTS;
              sanp_pkg::CT_CALENDAR: cc = sanp_pkg::CC_CALENDAR;
              sanp_pkg::CT_NOTES:    cc = sanp_pkg::CC_NOTES;
              default:               cc = sanp_pkg::CC_UNSUPPORTED;
            endcase
          end
          r.item_kind    = sanp_pkg::KIND_CONTENT_TYPE;
          r.content_code = cc;
          r.sync_index   = prs_sync_no;
          prs_phase      = sanp_pkg::PH_ULEN;
          prs_count      = '0;
        end
      end
      sanp_pkg::PH_ULEN: begin
        prs_remaining = b;
        if (b == 0) close_sync();
        else prs_phase = sanp_pkg::PH_URI;
      end
      sanp_pkg::PH_URI: begin
        r.item_kind  = sanp_pkg::KIND_URI;
        r.data_byte  = b;
        r.sync_index = prs_sync_no;
        prs_remaining--;
        if (prs_remaining == 0) close_sync();
      end
      sanp_pkg::PH_TRAIL, sanp_pkg::PH_ERROR: ;
      default: prs_phase = sanp_pkg::PH_ERROR;
    endcase
    if (last) begin
      r.message_done = 1'b1;
      if (prs_error != sanp_pkg::ST_OK) r.status = prs_error;
      else begin
        case (prs_phase)
          sanp_pkg::PH_DIGEST: r.status = sanp_pkg::ST_SHORT_DIGEST;
          sanp_pkg::PH_HEADER: r.status = sanp_pkg::ST_SHORT_HEADER;
          sanp_pkg::PH_IDENT:  r.status = sanp_pkg::ST_SHORT_ID;
          sanp_pkg::PH_BODY:
            r.status = empty_body_mode ? sanp_pkg::ST_OK : sanp_pkg::ST_BODY;
          sanp_pkg::PH_STYPE, sanp_pkg::PH_CTYPE, sanp_pkg::PH_ULEN:
            r.status = sanp_pkg::ST_SHORT_INFO;
          sanp_pkg::PH_URI:    r.status = sanp_pkg::ST_SHORT_URI;
          sanp_pkg::PH_TRAIL:  r.status = sanp_pkg::ST_OK;
          default:             r.status = sanp_pkg::ST_BODY;
        endcase
      end
      clear_parse_state();
    end
    return r;
  endfunction

  // a closing item with only kind, byte, message_done and status set
  function automatic sanp_pkg::result_t closing_item(input sanp_pkg::kind_t k,
                                                     input logic [7:0] d,
                                                     input sanp_pkg::status_t s);
    sanp_pkg::result_t r;
    r = '0;
    r.item_kind    = k;
    r.data_byte    = d;
    r.message_done = 1'b1;
    r.status       = s;
    return r;
  endfunction

  // random message in the shape of the current mode, then bent by the flavour
  function automatic void compose_message(input flavour_t fl);
    bit         dm_shape;
    logic [7:0] hi, lo;
    logic [9:0] ver;
    int         id_len, n_sync, u_len, keep, sel;
    dm_shape = empty_body_mode;
    if (fl == FL_OTHER_MODE) dm_shape = !dm_shape;
    msg_bytes.delete();
    repeat (16) msg_bytes.push_back(8'($urandom));
    if (fl == FL_BAD_VERSION) begin
      do begin
        hi = 8'($urandom);
        lo = 8'($urandom);
      end while ({hi, lo[7:6]} == sanp_pkg::VER_1_1 || {hi, lo[7:6]} == sanp_pkg::VER_1_2);
    end else begin
      ver = $urandom_range(0, 1) ? sanp_pkg::VER_1_2 : sanp_pkg::VER_1_1;
      hi  = ver[9:2];
      lo  = {ver[1:0], 6'($urandom)};
    end
    msg_bytes.push_back(hi);
    msg_bytes.push_back(lo);
    repeat (3) msg_bytes.push_back(8'($urandom));
    // session id now and then at its extremes
    sel = $urandom_range(0, 9);
    repeat (2) msg_bytes.push_back(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom));
    id_len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 8);
    msg_bytes.push_back(8'(id_len));
    repeat (id_len) msg_bytes.push_back(8'($urandom));
    if (!dm_shape) begin
      if (fl == FL_ZERO_COUNT) n_sync = 0;
      else n_sync = ($urandom_range(0, 11) == 0) ? 15 : $urandom_range(1, 3);
      msg_bytes.push_back({4'(n_sync), 4'($urandom)});
      repeat (n_sync) begin
        msg_bytes.push_back(8'($urandom));
        sel = $urandom_range(0, 6);
        msg_bytes.push_back(sel == 6 ? 8'($urandom) : 8'h00);
        msg_bytes.push_back(sel >= 5 ? 8'($urandom) : 8'h00);
        case (sel)
          0:       msg_bytes.push_back(8'h00);
          1:       msg_bytes.push_back(sanp_pkg::CT_CONTACTS);
          2:       msg_bytes.push_back(sanp_pkg::CT_CALENDAR);
          3:       msg_bytes.push_back(sanp_pkg::CT_NOTES);
          default: msg_bytes.push_back(8'($urandom));
        endcase
        u_len = ($urandom_range(0, 59) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 6);
        msg_bytes.push_back(8'(u_len));
        repeat (u_len) msg_bytes.push_back(8'($urandom));
      end
    end
    if (fl == FL_TRAILING) repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
    if (fl == FL_CUT) begin
      keep = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
  endfunction

  // hand one byte over, with bursts, gaps and the odd full drain before it;
  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                           input sanp_pkg::result_t want);
    sanp_pkg::result_t predicted;
    if ($urandom_range(0, 299) == 0) begin
      // hold off until every outstanding item has come back
      in_valid <= 1'b0;
      do @(negedge clk); while (items_due.size() != 0);
    end else if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    if (burst_left != 0) burst_left--;
    in_valid       <= 1'b1;
    msg_byte       <= b;
    end_of_message <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = parse_next_byte(b, last);
    bytes_counted++;
    items_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // mode register write, only once the parser has gone quiet
  task automatic write_mode(input logic v);
    in_valid <= 1'b0;
    do @(negedge clk); while (items_due.size() != 0);
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    empty_body_mode = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: readiness follows a randomly drawn style, redrawn when its span runs out
  always @(negedge clk) begin
    if (rx_style_left == 0) begin
      rx_style      = rx_style_t'($urandom_range(0, 3));
      rx_style_left = $urandom_range(20, 200);
    end
    rx_style_left--;
    rx_tick++;
    case (rx_style)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: out_ready <= (rx_tick[1:0] == 2'b00);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // every result transaction is matched against the oldest outstanding item
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (items_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, kind %0d", $time, item_kind);
        mismatch_count++;
      end else begin
        item_want = items_due.pop_front();
        check_field("item_kind", item_want.item_kind, item_kind);
        check_field("data_byte", item_want.data_byte, data_byte);
        check_field("version_code", item_want.version_code, version_code);
        check_field("ui_mode", item_want.ui_mode, ui_mode);
        check_field("server_init", item_want.server_init, server_init);
        check_field("session_id", item_want.session_id, session_id);
        check_field("sync_type", item_want.sync_type, sync_type);
        check_field("content_code", item_want.content_code, content_code);
        check_field("sync_index", item_want.sync_index, sync_index);
        check_field("message_done", item_want.message_done, message_done);
        check_field("status", item_want.status, status);
      end
    end
  end

  initial begin : stimulus
    sanp_pkg::result_t hdr_want;
    flavour_t          fl;
    int                phase_no, n_msgs, sel;
    clear_parse_state();

    // end on the very first byte, both byte extremes
    directed_rows[0] = '{8'h00, 1'b1, 1'b1,
                         closing_item(sanp_pkg::KIND_DIGEST, 8'h00, sanp_pkg::ST_SHORT_DIGEST)};
    directed_rows[1] = '{8'hFF, 1'b1, 1'b1,
                         closing_item(sanp_pkg::KIND_DIGEST, 8'hFF, sanp_pkg::ST_SHORT_DIGEST)};
    for (int i = 0; i < 16; i++) directed_rows[2 + i] = '{8'(i * 17), 1'b0, 1'b0, '0};
    // version 1.1 header with ui mode, initiator and session all ones
    directed_rows[18] = '{8'h02, 1'b0, 1'b0, '0};
    directed_rows[19] = '{8'hF8, 1'b0, 1'b0, '0};
    directed_rows[20] = '{8'hAA, 1'b0, 1'b0, '0};
    directed_rows[21] = '{8'h55, 1'b0, 1'b0, '0};
    directed_rows[22] = '{8'h00, 1'b0, 1'b0, '0};
    directed_rows[23] = '{8'hFF, 1'b0, 1'b0, '0};
    directed_rows[24] = '{8'hFF, 1'b0, 1'b0, '0};
    // identifier length given but message ends on it: short identifier
    hdr_want = '0;
    hdr_want.item_kind    = sanp_pkg::KIND_HEADER_DONE;
    hdr_want.ui_mode      = 2'd3;
    hdr_want.server_init  = 1'b1;
    hdr_want.session_id   = 16'hFFFF;
    hdr_want.message_done = 1'b1;
    hdr_want.status       = sanp_pkg::ST_SHORT_ID;
    directed_rows[25] = '{8'hFF, 1'b1, 1'b1, hdr_want};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      push_byte(directed_rows[i].msg_byte, directed_rows[i].eom, directed_rows[i].typed,
                directed_rows[i].want);

    // first two phases walk every flavour in each mode, later ones draw at random
    phase_no = 0;
    while (bytes_counted < ITEM_TARGET) begin
      write_mode(phase_no == 0 ? 1'b1 : phase_no == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      n_msgs = (phase_no < 2) ? NUM_FLAVOURS : $urandom_range(2, 6);
      for (int m = 0; m < n_msgs; m++) begin
        sel = $urandom_range(0, 99);
        if (phase_no < 2) fl = flavour_t'(m);
        else fl = sel < 50 ? FL_CLEAN : sel < 60 ? FL_TRAILING : sel < 75 ? FL_CUT :
                  sel < 83 ? FL_BAD_VERSION : sel < 90 ? FL_ZERO_COUNT : FL_OTHER_MODE;
        compose_message(fl);
        foreach (msg_bytes[i])
          push_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (items_due.size() != 0);
    // then wait on to catch any stray result transaction
    repeat (4) @(negedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
